/* design/sxtok_pkg.sv */
// Shared types and token codes for the s-expression tokenizer.
// No dependencies; imported by every module of the block.
package sxtok_pkg;

  localparam int KIND_W = 4;
  localparam int FIELD_W = 16;
  localparam int NUM_W = 31;

  localparam logic [KIND_W-1:0] KIND_OPEN = 4'd0;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd3;
  localparam logic [KIND_W-1:0] KIND_BOOL = 4'd4;
  localparam logic [KIND_W-1:0] KIND_STRING = 4'd5;
  localparam logic [KIND_W-1:0] KIND_QUOTE = 4'd6;
  localparam logic [KIND_W-1:0] KIND_QUASI = 4'd7;
  localparam logic [KIND_W-1:0] KIND_UNQUOTE = 4'd8;
  localparam logic [KIND_W-1:0] KIND_SPLICE = 4'd9;
  localparam logic [KIND_W-1:0] KIND_BAD_CHAR = 4'd10;
  localparam logic [KIND_W-1:0] KIND_BAD_HASH = 4'd11;
  localparam logic [KIND_W-1:0] KIND_END = 4'd12;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW = 2;
  localparam int RQ_CW = 3;

  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] start_pos;
    logic [FIELD_W-1:0] text_length;
    logic [NUM_W-1:0]   number_value;
    logic               bool_value;
    logic [FIELD_W-1:0] line_number;
    logic [7:0]         offending_byte;
    logic               last_result;
  } sxtok_result_t;

  typedef struct packed {
    logic [1:0]    count;
    sxtok_result_t r0;
    sxtok_result_t r1;
  } sxtok_step_t;

  typedef struct packed {
    logic             room;
    logic [RQ_CW-1:0] fill;
  } sxtok_rq_stat_t;

endpackage

/* design/sexpr_tokenizer.sv */
// Top level of the s-expression tokenizer: input register, lexer core, result queue.
// Depends on sxtok_pkg, sxtok_core and sxtok_rq.
//
// Usage:
//   in_*  : one source byte per request in in_tdata; in_tlast high marks end of
//           text (the byte is then ignored), flushing any pending token.
//   out_* : one token per request; out_tuser is the token kind, out_tlast marks
//           the final token caused by one input request.
//   A byte may cause zero, one or two tokens; end of text causes one or two.
// Path: a token passes through the input register and then the result queue
//   before it is presented on out_*.
// Throughput: one input request per cycle while each causes at most one token
//   and out_tready stays high; a byte that causes two tokens is drained by the
//   single output port, one token per request, from a four-entry result queue.
// Reset: rst_n low clears the lexer to blank mode, position 0, line 1, and
//   empties the queue.
// Stall: while out_tready is low, results wait in the queue; the input side
//   keeps accepting until the queue has no room for two more tokens, then
//   holds in_tready low until the output drains.
module sexpr_tokenizer import sxtok_pkg::*; #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [15:0] start_pos, [31:16] text_length,
                                  // [62:32] number_value, [63] bool_value,
                                  // [79:64] line_number, [87:80] offending_byte
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_result
);

  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           in_eoi_r;
  logic           step_go;
  logic [1:0]     push;
  sxtok_step_t    step;
  sxtok_result_t  head;
  sxtok_rq_stat_t rq_stat;

  assign step_go = in_valid_r && rq_stat.room;
  assign in_tready = !in_valid_r || step_go;
  assign push = step_go ? step.count : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eoi_r <= in_tlast;
    end
  end

  sxtok_core #(
    .POS_WIDTH (POS_WIDTH),
    .LINE_WIDTH(LINE_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_go     (step_go),
    .char_byte   (in_byte_r),
    .end_of_input(in_eoi_r),
    .step        (step)
  );

  sxtok_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .r0        (step.r0),
    .r1        (step.r1),
    .pop       (out_tvalid && out_tready),
    .head_valid(out_tvalid),
    .head      (head),
    .stat      (rq_stat)
  );

  assign out_tdata = {head.offending_byte, head.line_number, head.bool_value,
                      head.number_value, head.text_length, head.start_pos};
  assign out_tuser = head.token_kind;
  assign out_tlast = head.last_result;

`ifndef SYNTHESIS
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rq_stat.fill <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_eoi_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && in_eoi_r |-> step.count != 2'd0 &&
      ((step.count == 2'd1 && step.r0.token_kind == KIND_END) ||
       (step.count == 2'd2 && step.r1.token_kind == KIND_END)))
    else $error("end of input without end token");

  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && step.count == 2'd2 |-> !step.r0.last_result && step.r1.last_result)
    else $error("last flag misplaced in a two-token step");
`endif

endmodule

/* design/sxtok_core.sv */
// Lexer mode machine: state registers and the per-byte step logic.
// Depends on sxtok_pkg for token codes and the result types.
module sxtok_core import sxtok_pkg::*; #(
  parameter int POS_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_go,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output sxtok_step_t step
);

  localparam logic [2:0] M_BLANK = 3'd0;
  localparam logic [2:0] M_SYM = 3'd1;
  localparam logic [2:0] M_NUM = 3'd2;
  localparam logic [2:0] M_HASH = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;
  localparam logic [2:0] M_STRING = 3'd5;
  localparam logic [2:0] M_COMMA = 3'd6;
  localparam logic [2:0] M_HALT = 3'd7;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_OPEN = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  localparam int PosExt = (POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W;
  localparam int LineExt = (LINE_WIDTH > FIELD_W) ? LINE_WIDTH : FIELD_W;
  localparam int ProdW = NUM_W + 4;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  logic [2:0]            mode_r, mode_nxt;
  logic [POS_WIDTH-1:0]  pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]  start_r, start_nxt;
  logic [NUM_W-1:0]      acc_r, acc_nxt;
  logic [LINE_WIDTH-1:0] line_r, line_nxt;

  logic                  c_sym, c_digit, c_space;
  logic                  b_emit, b_set_start, b_set_acc;
  logic [KIND_W-1:0]     b_kind;
  logic [7:0]            b_off;
  logic [2:0]            b_mode;
  logic [POS_WIDTH-1:0]  b_start;
  logic [NUM_W-1:0]      b_acc;

  logic                  a_valid, b_valid, use_blank;
  logic [KIND_W-1:0]     a_kind, b_res_kind;
  logic [POS_WIDTH-1:0]  a_start, a_len;
  logic [NUM_W-1:0]      a_num;
  logic                  a_bv;
  logic [7:0]            a_off, b_res_off;
  logic [LINE_WIDTH-1:0] line_inc, line_res;
  logic [ProdW-1:0]      acc_prod;

  logic [PosExt-1:0]     a_start_x, a_len_x;
  logic [LineExt-1:0]    line_x;
  sxtok_result_t         a_res, b_res;

  always_comb begin
    c_sym = ((char_byte >= CH_LOW_A) && (char_byte <= CH_LOW_Z)) ||
            (char_byte == CH_QMARK) || (char_byte == CH_BANG) ||
            (char_byte == CH_PLUS) || (char_byte == CH_MINUS) ||
            (char_byte == CH_STAR) || (char_byte == CH_SLASH) ||
            (char_byte == CH_EQ) || (char_byte == CH_LT) || (char_byte == CH_GT);
    c_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    c_space = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
              (char_byte == CH_CR) || (char_byte == CH_LF);
  end

  // decode of one byte seen from blank mode
  always_comb begin
    b_emit = 1'b0;
    b_kind = KIND_OPEN;
    b_off = 8'd0;
    b_mode = M_BLANK;
    b_set_start = 1'b0;
    b_start = pos_r;
    b_set_acc = 1'b0;
    b_acc = NUM_W'(char_byte - CH_ZERO);
    case (char_byte)
      CH_OPEN: begin
        b_emit = 1'b1;
        b_kind = KIND_OPEN;
      end
      CH_CLOSE: begin
        b_emit = 1'b1;
        b_kind = KIND_CLOSE;
      end
      CH_HASH: b_mode = M_HASH;
      CH_QUOTE: begin
        b_emit = 1'b1;
        b_kind = KIND_QUOTE;
      end
      CH_BTICK: begin
        b_emit = 1'b1;
        b_kind = KIND_QUASI;
      end
      CH_COMMA: b_mode = M_COMMA;
      CH_SEMI: b_mode = M_COMMENT;
      CH_DQUOTE: begin
        b_mode = M_STRING;
        b_set_start = 1'b1;
        b_start = pos_r + 1'b1;
      end
      default: begin
        if (c_sym) begin
          b_mode = M_SYM;
          b_set_start = 1'b1;
        end else if (c_digit) begin
          b_mode = M_NUM;
          b_set_acc = 1'b1;
        end else if (!c_space) begin
          b_emit = 1'b1;
          b_kind = KIND_BAD_CHAR;
          b_off = char_byte;
          b_mode = M_HALT;
        end
      end
    endcase
  end

  always_comb begin
    acc_prod = {1'b0, acc_r, 3'd0} + {3'd0, acc_r, 1'b0} +
               ProdW'(char_byte - CH_ZERO);
  end

  always_comb begin
    line_inc = ((char_byte == CH_LF) && !(&line_r)) ? line_r + 1'b1 : line_r;
    mode_nxt = mode_r;
    pos_nxt = pos_r;
    start_nxt = start_r;
    acc_nxt = acc_r;
    line_nxt = line_r;
    line_res = line_inc;
    a_valid = 1'b0;
    a_kind = KIND_OPEN;
    a_start = '0;
    a_len = '0;
    a_num = '0;
    a_bv = 1'b0;
    a_off = 8'd0;
    use_blank = 1'b0;
    b_valid = 1'b0;
    b_res_kind = b_kind;
    b_res_off = b_off;
    if (end_of_input) begin
      line_res = line_r;
      b_valid = 1'b1;
      b_res_kind = KIND_END;
      b_res_off = 8'd0;
      case (mode_r)
        M_SYM: begin
          a_valid = 1'b1;
          a_kind = KIND_SYMBOL;
          a_start = start_r;
          a_len = pos_r - start_r;
        end
        M_NUM: begin
          a_valid = 1'b1;
          a_kind = KIND_NUMBER;
          a_num = acc_r;
        end
        M_COMMA: begin
          a_valid = 1'b1;
          a_kind = KIND_UNQUOTE;
        end
        default: a_valid = 1'b0;
      endcase
      mode_nxt = M_BLANK;
      pos_nxt = '0;
      start_nxt = '0;
      acc_nxt = '0;
      line_nxt = LINE_WIDTH'(1);
    end else begin
      pos_nxt = pos_r + 1'b1;
      if (mode_r != M_HALT) begin
        line_nxt = line_inc;
        case (mode_r)
          M_SYM: begin
            if (!(c_sym || c_digit)) begin
              a_valid = 1'b1;
              a_kind = KIND_SYMBOL;
              a_start = start_r;
              a_len = pos_r - start_r;
              use_blank = 1'b1;
            end
          end
          M_NUM: begin
            if (c_digit) begin
              acc_nxt = (acc_prod > ProdW'(NUM_MAX)) ? NUM_MAX : acc_prod[NUM_W-1:0];
            end else begin
              a_valid = 1'b1;
              a_kind = KIND_NUMBER;
              a_num = acc_r;
              use_blank = 1'b1;
            end
          end
          M_HASH: begin
            a_valid = 1'b1;
            if ((char_byte == CH_LOW_T) || (char_byte == CH_LOW_F)) begin
              a_kind = KIND_BOOL;
              a_bv = (char_byte == CH_LOW_T);
              mode_nxt = M_BLANK;
            end else begin
              a_kind = KIND_BAD_HASH;
              a_off = char_byte;
              mode_nxt = M_HALT;
            end
          end
          M_COMMENT: begin
            if ((char_byte == CH_LF) || (char_byte == CH_CR)) begin
              mode_nxt = M_BLANK;
            end
          end
          M_STRING: begin
            if (char_byte == CH_DQUOTE) begin
              a_valid = 1'b1;
              a_kind = KIND_STRING;
              a_start = start_r;
              a_len = pos_r - start_r;
              mode_nxt = M_BLANK;
            end
          end
          M_COMMA: begin
            a_valid = 1'b1;
            mode_nxt = M_BLANK;
            if (char_byte == CH_AT) begin
              a_kind = KIND_SPLICE;
            end else begin
              a_kind = KIND_UNQUOTE;
              use_blank = 1'b1;
            end
          end
          default: use_blank = 1'b1;
        endcase
        if (use_blank) begin
          mode_nxt = b_mode;
          b_valid = b_emit;
          if (b_set_start) begin
            start_nxt = b_start;
          end
          if (b_set_acc) begin
            acc_nxt = b_acc;
          end
        end
      end
    end
  end

  always_comb begin
    a_start_x = PosExt'(a_start);
    a_len_x = PosExt'(a_len);
    line_x = LineExt'(line_res);
    a_res = '{token_kind: a_kind, start_pos: a_start_x[FIELD_W-1:0],
              text_length: a_len_x[FIELD_W-1:0], number_value: a_num,
              bool_value: a_bv, line_number: line_x[FIELD_W-1:0],
              offending_byte: a_off, last_result: !b_valid};
    b_res = '{token_kind: b_res_kind, start_pos: '0, text_length: '0,
              number_value: '0, bool_value: 1'b0,
              line_number: line_x[FIELD_W-1:0], offending_byte: b_res_off,
              last_result: 1'b1};
    step.count = {1'b0, a_valid} + {1'b0, b_valid};
    step.r0 = a_valid ? a_res : b_res;
    step.r1 = b_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BLANK;
      pos_r <= '0;
      start_r <= '0;
      acc_r <= '0;
      line_r <= LINE_WIDTH'(1);
    end else if (step_go) begin
      mode_r <= mode_nxt;
      pos_r <= pos_nxt;
      start_r <= start_nxt;
      acc_r <= acc_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

/* design/sxtok_rq.sv */
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on sxtok_pkg for the result and status types.
module sxtok_rq import sxtok_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push,
  input  sxtok_result_t  r0,
  input  sxtok_result_t  r1,
  input  logic           pop,
  output logic           head_valid,
  output sxtok_result_t  head,
  output sxtok_rq_stat_t stat
);

  sxtok_result_t    entry_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0] fill_r, fill_nxt;
  logic [RQ_AW-1:0] wr_ptr_p1;

  always_comb begin
    wr_ptr_p1 = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push);
    rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop);
    fill_nxt = fill_r + RQ_CW'(push) - RQ_CW'(pop);
    head_valid = (fill_r != '0);
    head = entry_r[rd_ptr_r];
    stat.fill = fill_r;
    stat.room = (fill_r <= RQ_CW'(RQ_DEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      entry_r[wr_ptr_r] <= r0;
    end
    if (push == 2'd2) begin
      entry_r[wr_ptr_p1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
